FILE: design/barycentric_coordinates_defines.svh
// ---------------------------------------------------------------------------
// barycentric coordinates assertion macros
// shared property wrappers for the clocked checks of the block
// ---------------------------------------------------------------------------
`ifndef BARYCENTRIC_COORDINATES_DEFINES_SVH
`define BARYCENTRIC_COORDINATES_DEFINES_SVH

// check that is switched off while reset is high
`define BCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define BCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/bcc_pkg.sv
// ---------------------------------------------------------------------------
// bcc_pkg
// word types and widths shared by the barycentric coordinates pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int CW      = 24;   // input coordinate width
  localparam int EW      = 25;   // edge vector component width
  localparam int MW      = 50;   // edge component product width
  localparam int DW      = 52;   // dot product width
  localparam int HW      = 26;   // limb width for the split multiplier
  localparam int PPW     = 54;   // partial product width
  localparam int PW      = 104;  // full product width
  localparam int QW      = 31;   // quotient bits below the saturation limit
  localparam int RW      = PW + QW;
  localparam int OW      = 32;   // weight width
  localparam int DIV_LAT = QW + 2;

  localparam logic signed [OW-1:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [OW-1:0] W_MAX   = 32'sh7fffffff;
  localparam logic signed [OW-1:0] W_MIN   = 32'sh80000000;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } bcc_pt_t;

  typedef struct packed {
    logic signed [OW-1:0] weight_u;
    logic signed [OW-1:0] weight_v;
    logic signed [OW-1:0] weight_w;
    logic                 degenerate;
  } bcc_wt_t;

  typedef struct packed {
    logic en;
    logic vld;
  } bcc_ctl_t;

endpackage

`default_nettype wire

FILE: design/bcc_dot.sv
// ---------------------------------------------------------------------------
// bcc_dot
// edge vectors, component products and the five dot products, three stages
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_dot import bcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  bcc_ctl_t             ctl,
  input  bcc_pt_t              pt,
  output logic                 vld,
  output logic signed [DW-1:0] d00,
  output logic signed [DW-1:0] d01,
  output logic signed [DW-1:0] d11,
  output logic signed [DW-1:0] d20,
  output logic signed [DW-1:0] d21
);

  logic signed [EW-1:0] e0 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [MW-1:0] m00 [3];
  logic signed [MW-1:0] m01 [3];
  logic signed [MW-1:0] m11 [3];
  logic signed [MW-1:0] m20 [3];
  logic signed [MW-1:0] m21 [3];
  logic [1:0] vs;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs  <= '0;
      vld <= 1'b0;
    end else if (ctl.en) begin
      vs  <= {vs[0], ctl.vld};
      vld <= vs[1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      e0[0] <= EW'(pt.bx) - EW'(pt.ax);
      e0[1] <= EW'(pt.by) - EW'(pt.ay);
      e0[2] <= EW'(pt.bz) - EW'(pt.az);
      e1[0] <= EW'(pt.cx) - EW'(pt.ax);
      e1[1] <= EW'(pt.cy) - EW'(pt.ay);
      e1[2] <= EW'(pt.cz) - EW'(pt.az);
      e2[0] <= EW'(pt.px) - EW'(pt.ax);
      e2[1] <= EW'(pt.py) - EW'(pt.ay);
      e2[2] <= EW'(pt.pz) - EW'(pt.az);
      for (int k = 0; k < 3; k++) begin
        m00[k] <= e0[k] * e0[k];
        m01[k] <= e0[k] * e1[k];
        m11[k] <= e1[k] * e1[k];
        m20[k] <= e2[k] * e0[k];
        m21[k] <= e2[k] * e1[k];
      end
      d00 <= DW'(m00[0]) + DW'(m00[1]) + DW'(m00[2]);
      d01 <= DW'(m01[0]) + DW'(m01[1]) + DW'(m01[2]);
      d11 <= DW'(m11[0]) + DW'(m11[1]) + DW'(m11[2]);
      d20 <= DW'(m20[0]) + DW'(m20[1]) + DW'(m20[2]);
      d21 <= DW'(m21[0]) + DW'(m21[1]) + DW'(m21[2]);
    end
  end

endmodule

`default_nettype wire

FILE: design/bcc_mul.sv
// ---------------------------------------------------------------------------
// bcc_mul
// 52 by 52 signed multiply as four limb products, then a combining add
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_mul import bcc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  output logic signed [PW-1:0] p
);

  logic signed [HW-1:0]  ah, bh;
  logic signed [HW:0]    al, bl;
  logic signed [PPW-1:0] hh, hl, lh, ll;

  // upper limb signed, lower limb unsigned
  assign ah = a[DW-1:HW];
  assign bh = b[DW-1:HW];
  assign al = {1'b0, a[HW-1:0]};
  assign bl = {1'b0, b[HW-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= PPW'(ah * bh);
      hl <= PPW'(ah * bl);
      lh <= PPW'(al * bh);
      ll <= PPW'(al * bl);
      p  <= (PW'(hh) <<< (2 * HW)) + (PW'(hl) <<< HW) + (PW'(lh) <<< HW) + PW'(ll);
    end
  end

endmodule

`default_nettype wire

FILE: design/bcc_div.sv
// ---------------------------------------------------------------------------
// bcc_div
// pipelined restoring divider, one quotient bit per g_stage stage, signed saturation
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_div import bcc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic        [PW-1:0] num,
  input  logic        [PW-1:0] den,
  input  logic                 neg,
  output logic signed [OW-1:0] q
);

  logic [RW-1:0] r  [QW+1];
  logic [PW-1:0] d  [QW+1];
  logic [QW-1:0] qb [QW+1];
  logic [QW:0]   sat;
  logic [QW:0]   sg;

  // quotient of 2^31 or more saturates for either sign
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= RW'(num) >= (RW'(den) << (OW - 1 - 16));
      r[0]   <= RW'(num) << 16;
      d[0]   <= den;
      qb[0]  <= '0;
      sg[0]  <= neg;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW:0] trial;
    assign trial = {1'b0, r[s]} - ({1'b0, RW'(d[s])} << (QW - 1 - s));

    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]   <= trial[RW] ? r[s] : trial[RW-1:0];
        qb[s+1]  <= qb[s] | (QW'(!trial[RW]) << (QW - 1 - s));
        d[s+1]   <= d[s];
        sat[s+1] <= sat[s];
        sg[s+1]  <= sg[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sat[QW]) begin
        q <= sg[QW] ? W_MIN : W_MAX;
      end else if (sg[QW]) begin
        q <= -$signed({1'b0, qb[QW]});
      end else begin
        q <= $signed({1'b0, qb[QW]});
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/barycentric_coordinates.sv
// ---------------------------------------------------------------------------
// barycentric_coordinates
// barycentric weights of a query point against a 3d triangle, Q15.16 out
// ---------------------------------------------------------------------------
// A point and three corners enter on the pt channel (pt_valid, pt_stall, pt);
// the weights u, v, w and the degenerate flag leave on the rsp channel
// (rsp_valid, rsp_stall, rsp). A word is taken when valid is high and stall
// is low.
// One word can enter every cycle while pt_stall is low. A result word passes
// through 41 register stages: three stages of dot products, two of split
// multiplies, one subtract, one magnitude stage, 33 divider stages (one
// quotient bit in each but the first and last) and the output register.
// The whole pipeline advances together; while the output word is held by
// rsp_stall, pt_stall is raised and every stage keeps its contents, so no
// word is lost or repeated.
// A zero determinant gives zero weights with degenerate set.
// Synchronous reset clears all valid bits and holds pt_stall high; the block
// is ready for a word in the cycle after reset falls.
// ---------------------------------------------------------------------------
`default_nettype none

`include "barycentric_coordinates_defines.svh"

module barycentric_coordinates import bcc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pt_valid,
  output logic    pt_stall,
  input  bcc_pt_t pt,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output bcc_wt_t rsp
);

  localparam int TAIL = 4 + DIV_LAT;

  logic                 en;
  bcc_ctl_t             ctl;
  logic                 dot_vld;
  logic signed [DW-1:0] d00, d01, d11, d20, d21;
  logic signed [PW-1:0] p_den0, p_den1, p_v0, p_v1, p_w0, p_w1;
  logic signed [PW-1:0] den, nv, nw;
  logic        [PW-1:0] den_m, nv_m, nw_m;
  logic                 neg_v, neg_w, deg;
  logic signed [OW-1:0] qv, qw;
  logic [TAIL-1:0]      vchain;
  logic [DIV_LAT-1:0]   dchain;
  logic signed [OW+1:0] u_wide;
  logic signed [OW-1:0] u_sat;

  assign en       = !rsp_valid || !rsp_stall;
  assign pt_stall = rst || !en;
  assign ctl      = '{en: en, vld: pt_valid};

  bcc_dot u_dot (
    .clk (clk), .rst (rst), .ctl (ctl), .pt (pt), .vld (dot_vld),
    .d00 (d00), .d01 (d01), .d11 (d11), .d20 (d20), .d21 (d21)
  );

  bcc_mul u_mul_den0 (.clk (clk), .en (en), .a (d00), .b (d11), .p (p_den0));
  bcc_mul u_mul_den1 (.clk (clk), .en (en), .a (d01), .b (d01), .p (p_den1));
  bcc_mul u_mul_v0   (.clk (clk), .en (en), .a (d11), .b (d20), .p (p_v0));
  bcc_mul u_mul_v1   (.clk (clk), .en (en), .a (d01), .b (d21), .p (p_v1));
  bcc_mul u_mul_w0   (.clk (clk), .en (en), .a (d00), .b (d21), .p (p_w0));
  bcc_mul u_mul_w1   (.clk (clk), .en (en), .a (d01), .b (d20), .p (p_w1));

  always_ff @(posedge clk) begin
    if (en) begin
      den   <= p_den0 - p_den1;
      nv    <= p_v0 - p_v1;
      nw    <= p_w0 - p_w1;
      deg   <= (den == '0) || den[PW-1];
      den_m <= den;
      neg_v <= nv[PW-1];
      neg_w <= nw[PW-1];
      nv_m  <= nv[PW-1] ? PW'(-nv) : PW'(nv);
      nw_m  <= nw[PW-1] ? PW'(-nw) : PW'(nw);
      dchain <= {dchain[DIV_LAT-2:0], deg};
    end
  end

  bcc_div u_div_v (
    .clk (clk), .en (en), .num (nv_m), .den (den_m), .neg (neg_v), .q (qv)
  );
  bcc_div u_div_w (
    .clk (clk), .en (en), .num (nw_m), .den (den_m), .neg (neg_w), .q (qw)
  );

  assign u_wide = (OW+2)'(ONE_Q16) - (OW+2)'(qv) - (OW+2)'(qw);

  always_comb begin
    if (u_wide > (OW+2)'(W_MAX)) begin
      u_sat = W_MAX;
    end else if (u_wide < (OW+2)'(W_MIN)) begin
      u_sat = W_MIN;
    end else begin
      u_sat = u_wide[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vchain    <= '0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      vchain    <= {vchain[TAIL-2:0], dot_vld};
      rsp_valid <= vchain[TAIL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.degenerate <= dchain[DIV_LAT-1];
      rsp.weight_u   <= dchain[DIV_LAT-1] ? '0 : u_sat;
      rsp.weight_v   <= dchain[DIV_LAT-1] ? '0 : qv;
      rsp.weight_w   <= dchain[DIV_LAT-1] ? '0 : qw;
    end
  end

  `BCC_ASSERT(a_deg_zero, rsp_valid && rsp.degenerate |-> rsp.weight_u == '0 && rsp.weight_v == '0 && rsp.weight_w == '0, "degenerate word with non-zero weights")
  `BCC_ASSERT_ALWAYS(a_rst_clear, $past(rst) |-> !rsp_valid && !(|vchain), "valid bits survive reset")
  `BCC_ASSERT(a_u_sum, rsp_valid && !rsp.degenerate && (rsp.weight_v[OW-1:OW-3] == 3'b000 || rsp.weight_v[OW-1:OW-3] == 3'b111) && (rsp.weight_w[OW-1:OW-3] == 3'b000 || rsp.weight_w[OW-1:OW-3] == 3'b111) |-> rsp.weight_u == ONE_Q16 - rsp.weight_v - rsp.weight_w, "u is not one minus v minus w")

endmodule

`default_nettype wire
